@@ rtl/voxel_brick_isolate_fill_filter_unit_macros.svh @@
// Assertion macros shared by the voxel brick filter RTL.
`ifndef VOXEL_BRICK_ISOLATE_FILL_FILTER_UNIT_MACROS_SVH
`define VOXEL_BRICK_ISOLATE_FILL_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define VBIF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define VBIF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/vbif_pkg.sv @@
// Types and face constants for the voxel brick isolate and fill filter.
package vbif_pkg;

   localparam int unsigned MASK_W  = 64;
   localparam int unsigned COUNT_W = 7;

   // Face layers of a 4x4x4 brick, voxel (x,y,z) at bit x+4y+16z
   localparam logic [MASK_W-1:0] FACE_X0 = 64'h1111_1111_1111_1111;
   localparam logic [MASK_W-1:0] FACE_X3 = 64'h8888_8888_8888_8888;
   localparam logic [MASK_W-1:0] FACE_Y0 = 64'h000F_000F_000F_000F;
   localparam logic [MASK_W-1:0] FACE_Y3 = 64'hF000_F000_F000_F000;
   localparam logic [MASK_W-1:0] FACE_Z0 = 64'h0000_0000_0000_FFFF;

   typedef struct packed {
      logic [MASK_W-1:0] brick_mask;
      logic [MASK_W-1:0] neighbor_xp_mask;
      logic [MASK_W-1:0] neighbor_xm_mask;
      logic [MASK_W-1:0] neighbor_yp_mask;
      logic [MASK_W-1:0] neighbor_ym_mask;
      logic [MASK_W-1:0] neighbor_zp_mask;
      logic [MASK_W-1:0] neighbor_zm_mask;
   } req_type;

   typedef struct packed {
      logic [MASK_W-1:0]  filtered_mask;
      logic [COUNT_W-1:0] removed_count;
      logic [COUNT_W-1:0] filled_count;
   } rsp_type;

   // Filter core output: new mask and the voxels it changed
   typedef struct packed {
      logic [MASK_W-1:0] filtered_mask;
      logic [MASK_W-1:0] removed_mask;
      logic [MASK_W-1:0] filled_mask;
   } filt_type;

endpackage

@@ rtl/voxel_brick_isolate_fill_filter_unit.sv @@
// Top level of the voxel brick isolate-removal and enclosed-fill filter.
//
// Usage:
//   Drive req_data (the brick mask and its six face-neighbour masks) and raise
//   start; the transaction is taken at the rising edge where start is high and
//   busy is low. busy is always low, so a brick may be presented every cycle.
//   Each result appears on rsp_data for exactly one cycle with rsp_valid high:
//   the filtered mask and the counts of voxels cleared and set.
// Pipeline: input register, then single-pass filter and popcount into the result
//   register.
// Throughput: one brick per cycle; the input and result registers each advance
//   every cycle.
// Reset: clears both valid flags, so no result is issued until a new
//   transaction arrives; bricks in flight are dropped.
// Stall: the receiver has no back-pressure and must take each result in the
//   cycle it is shown.
`include "voxel_brick_isolate_fill_filter_unit_macros.svh"

module voxel_brick_isolate_fill_filter_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  vbif_pkg::req_type req_data,
   output logic              rsp_valid,
   output vbif_pkg::rsp_type rsp_data
);

   logic               req_valid_ff, req_valid_in;
   vbif_pkg::req_type  req_ff, req_in;
   logic               rsp_valid_ff, rsp_valid_in;
   vbif_pkg::rsp_type  rsp_ff, rsp_in;
   vbif_pkg::filt_type filt;
   logic [vbif_pkg::COUNT_W-1:0] removed_cnt, filled_cnt;

   // Never hold off a transaction
   assign busy = 1'b0;

   // Capture the incoming brick
   always_comb begin
      req_valid_in = start & ~busy;
      req_in       = req_data;
   end

   vbif_core u_core (
      .req_data  (req_ff),
      .filt_data (filt)
   );

   vbif_popcount u_removed_cnt (
      .bits_in   (filt.removed_mask),
      .count_out (removed_cnt)
   );

   vbif_popcount u_filled_cnt (
      .bits_in   (filt.filled_mask),
      .count_out (filled_cnt)
   );

   // Assemble the result transaction
   always_comb begin
      rsp_valid_in           = req_valid_ff;
      rsp_in.filtered_mask   = filt.filtered_mask;
      rsp_in.removed_count   = removed_cnt;
      rsp_in.filled_count    = filled_cnt;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   `VBIF_ASSERT_IMPL(a_accept_to_rsp, clock, reset, start && !busy, ##2 rsp_valid, "accepted brick gave no result two cycles later")
   `VBIF_ASSERT_NEXT(a_stage_to_rsp, clock, reset, req_valid_ff, rsp_valid, "registered brick did not reach the result register")
   `VBIF_ASSERT_IMPL(a_counts_bounded, clock, reset, rsp_valid, ({1'b0, rsp_data.removed_count} + {1'b0, rsp_data.filled_count} <= 8'd64), "removed and filled counts overlap")

endmodule

@@ rtl/vbif_core.sv @@
// Six-neighbour gather and isolate-removal / enclosed-fill logic for one brick.
module vbif_core (
   input  vbif_pkg::req_type  req_data,
   output vbif_pkg::filt_type filt_data
);

   logic [vbif_pkg::MASK_W-1:0] m;
   logic [vbif_pkg::MASK_W-1:0] px, mx, py, my, pz, mz;
   logic [vbif_pkg::MASK_W-1:0] any_nb, all_nb, kept, result;

   // Shift the brick one voxel along each axis, bringing in the facing layer
   always_comb begin
      m  = req_data.brick_mask;
      px = ((m >> 1) & ~vbif_pkg::FACE_X3)
         | ((req_data.neighbor_xp_mask & vbif_pkg::FACE_X0) << 3);
      mx = ((m << 1) & ~vbif_pkg::FACE_X0)
         | ((req_data.neighbor_xm_mask & vbif_pkg::FACE_X3) >> 3);
      py = ((m >> 4) & ~vbif_pkg::FACE_Y3)
         | ((req_data.neighbor_yp_mask & vbif_pkg::FACE_Y0) << 12);
      my = ((m << 4) & ~vbif_pkg::FACE_Y0)
         | ((req_data.neighbor_ym_mask & vbif_pkg::FACE_Y3) >> 12);
      pz = (m >> 16) | ((req_data.neighbor_zp_mask & vbif_pkg::FACE_Z0) << 48);
      mz = (m << 16) | (req_data.neighbor_zm_mask >> 48);
   end

   // Drop isolated voxels, fill fully enclosed holes
   always_comb begin
      any_nb = px | mx | py | my | pz | mz;
      all_nb = px & mx & py & my & pz & mz;
      kept   = m & any_nb;
      result = kept | (~kept & all_nb);
      filt_data.filtered_mask = result;
      filt_data.removed_mask  = m & ~result;
      filt_data.filled_mask   = result & ~m;
   end

endmodule

@@ rtl/vbif_popcount.sv @@
// Adder-tree population count of a 64-bit mask.
module vbif_popcount (
   input  logic [vbif_pkg::MASK_W-1:0]  bits_in,
   output logic [vbif_pkg::COUNT_W-1:0] count_out
);

   logic [1:0] lvl1 [32];
   logic [2:0] lvl2 [16];
   logic [3:0] lvl3 [8];
   logic [4:0] lvl4 [4];
   logic [5:0] lvl5 [2];

   // Sum pairs at each level, widening by one bit
   always_comb begin
      for (int i = 0; i < 32; i++) begin
         lvl1[i] = {1'b0, bits_in[2*i]} + {1'b0, bits_in[2*i+1]};
      end
      for (int i = 0; i < 16; i++) begin
         lvl2[i] = {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
      end
      for (int i = 0; i < 8; i++) begin
         lvl3[i] = {1'b0, lvl2[2*i]} + {1'b0, lvl2[2*i+1]};
      end
      for (int i = 0; i < 4; i++) begin
         lvl4[i] = {1'b0, lvl3[2*i]} + {1'b0, lvl3[2*i+1]};
      end
      for (int i = 0; i < 2; i++) begin
         lvl5[i] = {1'b0, lvl4[2*i]} + {1'b0, lvl4[2*i+1]};
      end
      count_out = {1'b0, lvl5[0]} + {1'b0, lvl5[1]};
   end

endmodule

@@ test/vbif_brick_checker.sv @@
// Checker for the voxel brick filter: predicts each brick result and compares it.
`timescale 1ns / 100ps

module vbif_brick_checker
   import vbif_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      bad_bricks,
   output int      bricks_in_flight
);

   localparam int REPORT_LIMIT = 10;

   rsp_type expected_bricks[$];
   int      bad_count = 0;

   // Count the set voxels of a mask
   function automatic logic [COUNT_W-1:0] count_voxels(logic [MASK_W-1:0] mask);
      logic [COUNT_W-1:0] total;
      total = '0;
      for (int i = 0; i < MASK_W; i++) begin
         total += COUNT_W'(mask[i]);
      end
      return total;
   endfunction

   // Remove isolated voxels and fill enclosed holes of one brick
   function automatic rsp_type filter_brick(req_type brick);
      logic [MASK_W-1:0] occ;
      logic [MASK_W-1:0] at_xp, at_xm, at_yp, at_ym, at_zp, at_zm;
      logic [MASK_W-1:0] any_nb, all_nb, kept, new_mask;
      rsp_type           res;
      occ = brick.brick_mask;
      // Shift each neighbour onto the voxel, pulling cross-face bits from the adjacent brick
      at_xp = ((occ >> 1) & ~FACE_X3) | ((brick.neighbor_xp_mask & FACE_X0) << 3);
      at_xm = ((occ << 1) & ~FACE_X0) | ((brick.neighbor_xm_mask & FACE_X3) >> 3);
      at_yp = ((occ >> 4) & ~FACE_Y3) | ((brick.neighbor_yp_mask & FACE_Y0) << 12);
      at_ym = ((occ << 4) & ~FACE_Y0) | ((brick.neighbor_ym_mask & FACE_Y3) >> 12);
      at_zp = (occ >> 16) | ((brick.neighbor_zp_mask & FACE_Z0) << 48);
      at_zm = (occ << 16) | (brick.neighbor_zm_mask >> 48);
      any_nb = at_xp | at_xm | at_yp | at_ym | at_zp | at_zm;
      all_nb = at_xp & at_xm & at_yp & at_ym & at_zp & at_zm;
      kept     = occ & any_nb;
      new_mask = kept | (~kept & all_nb);
      res.filtered_mask = new_mask;
      res.removed_count = count_voxels(occ & ~new_mask);
      res.filled_count  = count_voxels(new_mask & ~occ);
      return res;
   endfunction

   // Retire results against the oldest prediction, then queue new transactions
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_bricks.size() == 0) begin
               bad_count++;
               if (bad_count <= REPORT_LIMIT)
                  $display("%0t: unexpected result mask=%h removed=%0d filled=%0d",
                           $realtime, rsp_data.filtered_mask, rsp_data.removed_count,
                           rsp_data.filled_count);
            end else begin
               want = expected_bricks.pop_front();
               if (rsp_data.filtered_mask !== want.filtered_mask
                   || rsp_data.removed_count !== want.removed_count
                   || rsp_data.filled_count !== want.filled_count) begin
                  bad_count++;
                  if (bad_count <= REPORT_LIMIT) begin
                     $display("%0t: brick result differs", $realtime);
                     $display("   filtered_mask exp %h got %h",
                              want.filtered_mask, rsp_data.filtered_mask);
                     $display("   removed_count exp %0d got %0d",
                              want.removed_count, rsp_data.removed_count);
                     $display("   filled_count  exp %0d got %0d",
                              want.filled_count, rsp_data.filled_count);
                  end
               end
            end
         end
         if (start && !busy)
            expected_bricks.push_back(filter_brick(req_data));
      end
      bad_bricks       <= bad_count;
      bricks_in_flight <= expected_bricks.size();
   end

endmodule

@@ test/tb_top.sv @@
// Testbench top for the voxel brick filter: stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb_top;
   import vbif_pkg::*;

   localparam int RANDOM_BRICKS = 450;
   localparam int STEADY_TAIL   = 60;
   localparam int STALL_LIMIT   = 200;
   localparam logic [MASK_W-1:0] ALL_ONES = '1;
   localparam logic [MASK_W-1:0] FACE_Z3  = 64'hFFFF_0000_0000_0000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      bad_bricks;
   int      bricks_in_flight;
   int      quiet_cycles = 0;

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   voxel_brick_isolate_fill_filter_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   vbif_brick_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data),
      .bad_bricks       (bad_bricks),
      .bricks_in_flight (bricks_in_flight)
   );

   function automatic req_type make_brick(logic [MASK_W-1:0] occ,
                                          logic [MASK_W-1:0] xp, logic [MASK_W-1:0] xm,
                                          logic [MASK_W-1:0] yp, logic [MASK_W-1:0] ym,
                                          logic [MASK_W-1:0] zp, logic [MASK_W-1:0] zm);
      req_type b;
      b.brick_mask       = occ;
      b.neighbor_xp_mask = xp;
      b.neighbor_xm_mask = xm;
      b.neighbor_yp_mask = yp;
      b.neighbor_ym_mask = ym;
      b.neighbor_zp_mask = zp;
      b.neighbor_zm_mask = zm;
      return b;
   endfunction

   // Voxels whose x+y+z is even
   function automatic logic [MASK_W-1:0] parity_mask();
      logic [MASK_W-1:0] m;
      m = '0;
      for (int i = 0; i < MASK_W; i++) begin
         m[i] = ((i % 4) + ((i / 4) % 4) + (i / 16)) % 2 == 0;
      end
      return m;
   endfunction

   function automatic logic [MASK_W-1:0] any_bits();
      return {$urandom, $urandom};
   endfunction

   // Random occupancy with a spread of densities so both isolation and holes occur
   function automatic logic [MASK_W-1:0] random_occupancy();
      case ($urandom_range(0, 4))
         0: return any_bits();
         1: return any_bits() & any_bits() & any_bits();
         2: return any_bits() | any_bits() | any_bits();
         3: return ~(any_bits() & any_bits() & any_bits() & any_bits());
         default: return any_bits() & any_bits() & any_bits() & any_bits();
      endcase
   endfunction

   // Neighbour brick: absent, solid or partly filled
   function automatic logic [MASK_W-1:0] random_neighbour();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return ALL_ONES;
         default: return random_occupancy();
      endcase
   endfunction

   // Present one transaction and hold it until the block takes it
   task automatic send_brick(req_type b);
      req_data <= b;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_burst();
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clock);
   endtask

   // Abort when nothing has moved for too long
   initial begin
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      req_type           directed[$];
      logic [MASK_W-1:0] chk;
      logic [MASK_W-1:0] corner_hole;
      logic [MASK_W-1:0] inner_hole;
      chk         = parity_mask();
      corner_hole = ALL_ONES & ~64'h1;
      inner_hole  = ALL_ONES & ~(64'h1 << 21);

      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Extremes of every field
      directed.push_back(make_brick('0, '0, '0, '0, '0, '0, '0));
      directed.push_back(make_brick(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                                    ALL_ONES, ALL_ONES));
      directed.push_back(make_brick(ALL_ONES, '0, '0, '0, '0, '0, '0));
      directed.push_back(make_brick('0, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                                    ALL_ONES, ALL_ONES));
      // Isolated interior voxel is dropped
      directed.push_back(make_brick(64'h1 << 21, '0, '0, '0, '0, '0, '0));
      // Face voxels kept alive by one solid neighbour brick each
      directed.push_back(make_brick(64'h1, '0, ALL_ONES, '0, '0, '0, '0));
      directed.push_back(make_brick(64'h1, '0, '0, '0, ALL_ONES, '0, '0));
      directed.push_back(make_brick(64'h1, '0, '0, '0, '0, '0, ALL_ONES));
      directed.push_back(make_brick(64'h1 << 63, ALL_ONES, '0, '0, '0, '0, '0));
      directed.push_back(make_brick(64'h1 << 63, '0, '0, ALL_ONES, '0, '0, '0));
      directed.push_back(make_brick(64'h1 << 63, '0, '0, '0, '0, ALL_ONES, '0));
      // Enclosed holes: interior always, corner only against solid neighbours
      directed.push_back(make_brick(inner_hole, '0, '0, '0, '0, '0, '0));
      directed.push_back(make_brick(corner_hole, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                                    ALL_ONES, ALL_ONES));
      directed.push_back(make_brick(corner_hole, '0, '0, '0, '0, '0, '0));
      // Checkerboards: maximum removal and fill together
      directed.push_back(make_brick(chk, '0, '0, '0, '0, '0, '0));
      directed.push_back(make_brick(chk, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                                    ALL_ONES, ALL_ONES));
      directed.push_back(make_brick(~chk, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                                    ALL_ONES, ALL_ONES));
      // Only the facing layers set, then everything but the facing layers
      directed.push_back(make_brick(~chk, FACE_X0, FACE_X3, FACE_Y0, FACE_Y3,
                                    FACE_Z0, FACE_Z3));
      directed.push_back(make_brick(corner_hole, ~FACE_X0, ~FACE_X3, ~FACE_Y0, ~FACE_Y3,
                                    ~FACE_Z0, ~FACE_Z3));
      directed.push_back(make_brick(~chk, ~FACE_X0, ~FACE_X3, ~FACE_Y0, ~FACE_Y3,
                                    ~FACE_Z0, ~FACE_Z3));

      foreach (directed[i]) begin
         if ($urandom_range(0, 3) == 0)
            idle_burst();
         send_brick(directed[i]);
      end

      // Random bricks, steady stream over the tail
      for (int i = 0; i < RANDOM_BRICKS; i++) begin
         if (i < RANDOM_BRICKS - STEADY_TAIL && $urandom_range(0, 3) == 0)
            idle_burst();
         send_brick(make_brick(random_occupancy(), random_neighbour(), random_neighbour(),
                               random_neighbour(), random_neighbour(),
                               random_neighbour(), random_neighbour()));
      end
      start <= 1'b0;

      // Drain outstanding results, then allow for the pipeline latency
      while (bricks_in_flight != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (bad_bricks == 0 && bricks_in_flight == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
